### design/hsmt_pkg.sv
// Shared types and constants for the hashed set membership table.
`timescale 1ns / 1ps

package hsmt_pkg;

  // Default sizing handed to the top level parameters
  localparam int MAX_BUCKETS_DEF = 64;
  localparam int WAYS_DEF        = 8;
  localparam int KEY_BITS_DEF    = 32;

  // Fixed field widths
  localparam int KEY_FIELD_W = 32;
  localparam int CNT_W       = 7;
  localparam int OUT_W       = 8;

  // Register map, word index taken from paddr[2]
  localparam logic [0:0]       REG_BUCKET_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 7'd64;

  // Actions carried in tuser; the unused code behaves as a query
  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_ERASE = 2'd2
  } action_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PROBE,
    ST_DRAIN,
    ST_UPDATE
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic load;
    logic div_step;
    logic probe_rd;
    logic update;
  } hsmt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic way_last;
    logic out_free;
  } hsmt_sts_t;

endpackage

### design/hsmt_dp.sv
// Datapath: remainder unit, slot memory, way probe and result register.
`timescale 1ns / 1ps

module hsmt_dp import hsmt_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hsmt_cmd_t              cmd_i,
  output hsmt_sts_t              sts_o,
  input  logic [KEY_FIELD_W-1:0] key_i,
  input  logic [1:0]             action_i,
  input  logic [CNT_W-1:0]       bucket_count_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [OUT_W-1:0]       out_data_o
);

  localparam int KW    = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
  localparam int SLOTS = MAX_BUCKETS * WAYS;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int DW    = $clog2(KW);
  localparam int CLAMP = (MAX_BUCKETS > 127) ? 127 : MAX_BUCKETS;
  localparam logic [CNT_W-1:0] DIV_MAX = CNT_W'(CLAMP);

  logic [KW-1:0]    key_q;
  logic [1:0]       action_q;
  logic [KW-1:0]    dividend_q;
  logic [CNT_W-1:0] rem_q, divisor_q;
  logic [DW-1:0]    div_cnt_q;
  logic [WW-1:0]    way_q, chk_way_q, hit_way_q, free_way_q;
  logic             chk_pend_q, hit_q, free_q;
  logic [AW-1:0]    clr_addr_q;
  logic [KW:0]      mem_q [SLOTS];
  logic [KW:0]      rd_q;
  logic             out_valid_q, out_present_q, out_full_q;
  logic [5:0]       out_bucket_q;

  logic [CNT_W-1:0] divisor_d, rem_d;
  logic [CNT_W:0]   trial;
  logic             trial_ge;
  logic [AW-1:0]    base, probe_addr, waddr;
  logic [KW:0]      wdata;
  logic             we, full;

  // Divisor clamp: zero acts as one, large counts saturate
  always_comb begin
    if (bucket_count_i == '0) begin
      divisor_d = CNT_W'(1);
    end else if (bucket_count_i > DIV_MAX) begin
      divisor_d = DIV_MAX;
    end else begin
      divisor_d = bucket_count_i;
    end
  end

  // One restoring remainder step per cycle, MSB of the key first
  assign trial    = {rem_q, dividend_q[KW-1]};
  assign trial_ge = trial >= {1'b0, divisor_q};
  assign rem_d    = trial_ge ? CNT_W'(trial - {1'b0, divisor_q}) : trial[CNT_W-1:0];

  // Slot addressing: bucket base plus way
  assign base       = AW'(AW'(rem_q) * AW'(WAYS));
  assign probe_addr = base + AW'(way_q);

  // Memory write selection: clearing pass or the set update
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr_q;
    wdata = '0;
    full  = 1'b0;
    if (cmd_i.clear_step) begin
      we = 1'b1;
    end else if (cmd_i.update) begin
      case (action_e'(action_q))
        ACT_ADD: begin
          if (!hit_q && free_q) begin
            we    = 1'b1;
            waddr = base + AW'(free_way_q);
            wdata = {1'b1, key_q};
          end
          full = !hit_q && !free_q;
        end
        ACT_ERASE: begin
          if (hit_q) begin
            we    = 1'b1;
            waddr = base + AW'(hit_way_q);
            wdata = {1'b0, key_q};
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot memory: valid bit over key, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_rd) begin
      rd_q <= mem_q[probe_addr];
    end
  end

  // Item payload and remainder registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q      <= key_i[KW-1:0];
      action_q   <= action_i;
      dividend_q <= key_i[KW-1:0];
      rem_q      <= '0;
      divisor_q  <= divisor_d;
    end else if (cmd_i.div_step) begin
      dividend_q <= {dividend_q[KW-2:0], 1'b0};
      rem_q      <= rem_d;
    end
  end

  // Counters, probe tracking and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q   <= '0;
      way_q       <= '0;
      chk_pend_q  <= 1'b0;
      chk_way_q   <= '0;
      hit_q       <= 1'b0;
      hit_way_q   <= '0;
      free_q      <= 1'b0;
      free_way_q  <= '0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end

      if (cmd_i.load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DW'(1);
      end

      chk_pend_q <= cmd_i.probe_rd;
      chk_way_q  <= way_q;
      if (cmd_i.load) begin
        way_q <= '0;
      end else if (cmd_i.probe_rd) begin
        way_q <= way_q + WW'(1);
      end

      // first matching way and first free way
      if (cmd_i.load) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (chk_pend_q) begin
        if (rd_q[KW]) begin
          if (!hit_q && rd_q[KW-1:0] == key_q) begin
            hit_q     <= 1'b1;
            hit_way_q <= chk_way_q;
          end
        end else if (!free_q) begin
          free_q     <= 1'b1;
          free_way_q <= chk_way_q;
        end
      end

      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_present_q <= hit_q;
      out_full_q    <= full;
      out_bucket_q  <= rem_q[5:0];
    end
  end

  assign sts_o.clr_last = clr_addr_q == AW'(SLOTS - 1);
  assign sts_o.div_last = div_cnt_q == DW'(KW - 1);
  assign sts_o.way_last = way_q == WW'(WAYS - 1);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {out_bucket_q, out_full_q, out_present_q};

endmodule

### design/hsmt_ctrl.sv
// Controller: runs the clearing pass after reset, then sequences remainder, probe and update for each word.
`timescale 1ns / 1ps

module hsmt_ctrl import hsmt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hsmt_sts_t sts_i,
  output hsmt_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register; the clearing pass runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.probe_rd = 1'b1;
        if (sts_i.way_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### design/hashed_set_membership_table.sv
// Top level of the hashed set membership table: config register, controller, datapath.
`timescale 1ns / 1ps

// Keeps a set of keys in MAX_BUCKETS buckets of WAYS slots. Each input word
// (tuser = action, tdata = key) yields one output word. The bucket is key
// modulo bucket_count (zero acts as one, values above MAX_BUCKETS saturate).
// An item runs through a restoring divider at one remainder bit per cycle,
// then through one way per cycle on the single read port of the slot memory,
// then the last compare and the update. One item is in work at a time;
// the result register lets the next item be accepted while a result waits.
// After reset a clearing pass writes all MAX_BUCKETS*WAYS slots (512 at
// defaults) and empties the slot memory while s_axis_tready stays low;
// register writes are taken throughout. bucket_count lies at address 0; the
// user must write it only while idle, which the block itself does not enforce.
module hashed_set_membership_table import hsmt_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF,
  parameter int WAYS        = WAYS_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [KEY_FIELD_W-1:0] s_axis_tdata,   // [31:0] key
  input  logic [1:0]             s_axis_tuser,   // [1:0] action
  // output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_W-1:0]       m_axis_tdata,   // [0] was_present, [1] bucket_full,
                                                 // [7:2] bucket_index
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [CNT_W-1:0] bucket_count_q;
  logic             cfg_wr;
  hsmt_cmd_t        cmd;
  hsmt_sts_t        sts;

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_count_q <= BUCKET_COUNT_RST;
    end else if (cfg_wr && paddr[2] == REG_BUCKET_COUNT) begin
      bucket_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? {25'b0, bucket_count_q} : 32'b0;

  hsmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hsmt_dp #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .WAYS        (WAYS),
    .KEY_BITS    (KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .key_i          (s_axis_tdata),
    .action_i       (s_axis_tuser),
    .bucket_count_i (bucket_count_q),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_data_o     (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // A dropped add only happens for an absent key
  a_full_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("bucket_full set together with was_present");

  // Bucket index stays inside the built buckets
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (int'(m_axis_tdata[7:2]) < MAX_BUCKETS))
    else $error("bucket_index beyond MAX_BUCKETS");

  // One item in work: no acceptance in the cycle after one
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in work");
`endif

endmodule

### tb/hashed_set_membership_table_tb.sv
// Self-checking testbench for the hashed set membership table: directed table, random phases.
`timescale 1ns / 1ps

module hashed_set_membership_table_tb;
  import hsmt_pkg::*;

  localparam int          SLOTS        = MAX_BUCKETS_DEF * WAYS_DEF;
  localparam logic [1:0]  ACT_RSVD     = 2'd3;   // unused code, behaves as a query
  localparam logic [2:0]  ADDR_CNT     = {REG_BUCKET_COUNT, 2'b00};
  localparam int          DIR_N        = 25;
  localparam int          PHASES       = 10;
  localparam int          PHASE_ITEMS  = 68;
  localparam int          END_WAIT     = 60;     // a bit over one item's latency
  localparam int          STALL_LIMIT  = 5000;   // covers the clearing pass and long stalls
  localparam int          REPORT_MAX   = 10;

  // Result word as packed on m_axis_tdata: [7:2] bucket, [1] full, [0] hit
  typedef struct packed {
    logic [5:0] idx;
    logic       full;
    logic       hit;
  } result_t;

  typedef struct {
    logic [1:0]  act;
    logic [31:0] key;
    bit          typed;
    result_t     res;
  } dir_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [KEY_FIELD_W-1:0] s_axis_tdata  = '0;   // [31:0] key
  logic [1:0]             s_axis_tuser  = '0;   // [1:0] action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_W-1:0]       m_axis_tdata;         // [0] was_present, [1] bucket_full,
                                                // [7:2] bucket_index
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [2:0]             paddr         = '0;
  logic [31:0]            pwdata        = '0;
  logic [31:0]            prdata;
  logic                   pready;

  hashed_set_membership_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the table: slot memory, valid bits and bucket count
  logic [31:0]       shadow_key   [SLOTS];
  bit                shadow_valid [SLOTS];
  logic [CNT_W-1:0]  shadow_cnt;
  logic [31:0]       key_pool [$];        // recently added keys, reused to hit the set
  result_t           due_q [$];           // results owed by the block, oldest first
  int unsigned       err_cnt      = 0;
  int unsigned       tx_gap_pct   = 0;
  int unsigned       rx_stall_pct = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       cnt_plan [PHASES] = '{1, 0, 2, 64, 127, 65, 3, 8, 33, 64};
  result_t           got_word;
  result_t           want_word;

  // Directed rows; typed expectations only where they are obvious
  dir_row_t dir_tab [DIR_N] = '{
    '{ACT_QUERY, 32'h0000_0000, 1'b1, {6'd0,  1'b0, 1'b0}},  // empty after reset
    '{ACT_ADD,   32'h0000_0000, 1'b1, {6'd0,  1'b0, 1'b0}},
    '{ACT_ADD,   32'h0000_0000, 1'b1, {6'd0,  1'b0, 1'b1}},  // add of present key
    '{ACT_QUERY, 32'h0000_0000, 1'b1, {6'd0,  1'b0, 1'b1}},
    '{ACT_ERASE, 32'h0000_0000, 1'b1, {6'd0,  1'b0, 1'b1}},
    '{ACT_ERASE, 32'h0000_0000, 1'b1, {6'd0,  1'b0, 1'b0}},  // erase of absent key
    '{ACT_ADD,   32'hFFFF_FFFF, 1'b1, {6'd63, 1'b0, 1'b0}},
    '{ACT_RSVD,  32'hFFFF_FFFF, 1'b1, {6'd63, 1'b0, 1'b1}},  // unused action = query
    '{ACT_QUERY, 32'hFFFF_FFFF, 1'b1, {6'd63, 1'b0, 1'b1}},
    '{ACT_ADD,   32'd5,         1'b0, '0},                   // fill bucket 5
    '{ACT_ADD,   32'd69,        1'b0, '0},
    '{ACT_ADD,   32'd133,       1'b0, '0},
    '{ACT_ADD,   32'd197,       1'b0, '0},
    '{ACT_ADD,   32'd261,       1'b0, '0},
    '{ACT_ADD,   32'd325,       1'b0, '0},
    '{ACT_ADD,   32'd389,       1'b0, '0},
    '{ACT_ADD,   32'd453,       1'b0, '0},
    '{ACT_ADD,   32'd517,       1'b1, {6'd5,  1'b1, 1'b0}},  // bucket full, dropped
    '{ACT_ADD,   32'd197,       1'b1, {6'd5,  1'b0, 1'b1}},  // present in full bucket
    '{ACT_ERASE, 32'd197,       1'b0, '0},
    '{ACT_ADD,   32'd517,       1'b0, '0},                   // takes the freed way
    '{ACT_QUERY, 32'd517,       1'b0, '0},
    '{ACT_ADD,   32'h5555_5555, 1'b0, '0},
    '{ACT_ERASE, 32'hAAAA_AAAA, 1'b0, '0},
    '{ACT_ADD,   32'hAAAA_AAAA, 1'b0, '0}
  };

  // Effective bucket count: zero acts as one, large values saturate
  function automatic int unsigned bucket_span();
    if (shadow_cnt == '0) return 1;
    if (shadow_cnt > MAX_BUCKETS_DEF) return MAX_BUCKETS_DEF;
    return shadow_cnt;
  endfunction

  // Apply one word to the shadow set and return the result it owes
  function automatic result_t apply_to_set(logic [1:0] act, logic [31:0] key);
    int unsigned bkt;
    int unsigned base;
    int          hit_way;
    int          free_way;
    result_t     res;
    bkt      = key % bucket_span();
    base     = bkt * WAYS_DEF;
    hit_way  = -1;
    free_way = -1;
    res      = '0;
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (shadow_valid[base + w]) begin
        if (hit_way < 0 && shadow_key[base + w] == key) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    case (act)
      ACT_ADD: begin
        if (hit_way < 0) begin
          if (free_way >= 0) begin
            shadow_key[base + free_way]   = key;
            shadow_valid[base + free_way] = 1'b1;
            key_pool.push_back(key);
            if (key_pool.size() > 48) void'(key_pool.pop_front());
          end else begin
            res.full = 1'b1;
          end
        end
      end
      ACT_ERASE: begin
        if (hit_way >= 0) shadow_valid[base + hit_way] = 1'b0;
      end
      default: ;
    endcase
    res.hit = (hit_way >= 0);
    res.idx = bkt[5:0];
    return res;
  endfunction

  function automatic logic [1:0] pick_action();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return ACT_ADD;
    if (sel < 65) return ACT_QUERY;
    if (sel < 95) return ACT_ERASE;
    return ACT_RSVD;
  endfunction

  // Mix of reused keys, keys crowded into a few buckets, and wide values
  function automatic logic [31:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40 && key_pool.size() > 0)
      return key_pool[$urandom_range(key_pool.size() - 1)];
    if (sel < 75)
      return $urandom_range(11) * bucket_span() + $urandom_range(2);
    if (sel < 90)
      return $urandom;
    if (sel < 95)
      return 32'hFFFF_FFFF - $urandom_range(200);
    return $urandom_range(200);
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Present one word on the input stream; called and returns at a falling edge
  task automatic send_word(input logic [1:0] act, input logic [31:0] key,
                           input bit typed, input result_t typed_res);
    result_t pred;
    while (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = apply_to_set(act, key);
    due_q.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  // Hold the input off until every owed result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (due_q.size() != 0);
  endtask

  // Write bucket_count, then read it back
  task automatic write_bucket_count(input logic [CNT_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CNT;
    pwdata  <= {{(32-CNT_W){1'b0}}, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_cnt = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(32-CNT_W){1'b0}}, val})
      note_error($sformatf("bucket_count read back %0h, wrote %0h", prdata, val));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_word = result_t'(m_axis_tdata);
      if (due_q.size() == 0) begin
        note_error($sformatf("unexpected result word %02h", m_axis_tdata));
      end else begin
        want_word = due_q.pop_front();
        if (got_word.hit !== want_word.hit || got_word.full !== want_word.full ||
            got_word.idx !== want_word.idx)
          note_error($sformatf("present/full/bucket exp %0b/%0b/%0d got %0b/%0b/%0d",
                               want_word.hit, want_word.full, want_word.idx,
                               got_word.hit, got_word.full, got_word.idx));
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_key[i]   = '0;
      shadow_valid[i] = 1'b0;
    end
    shadow_cnt = BUCKET_COUNT_RST;
    cnt_plan[PHASES-1] = $urandom_range(1, 127);
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table at the reset bucket count, no idling
    for (int r = 0; r < DIR_N; r++)
      send_word(dir_tab[r].act, dir_tab[r].key, dir_tab[r].typed, dir_tab[r].res);

    // random phases, each with its own bucket count and idling mode
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_bucket_count(cnt_plan[ph][CNT_W-1:0]);
      case (ph % 4)
        0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_gap_pct = 76; rx_stall_pct = 0;  end
        2: begin tx_gap_pct = 0;  rx_stall_pct = 76; end
        default: begin tx_gap_pct = 33; rx_stall_pct = 33; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && ph % 3 == 0) drain_results();
        send_word(pick_action(), pick_key(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && due_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
